// File: sv/prld_pkg.sv
// Shared types and constants of the paired run-length decoder.
// Used by the controller, the datapath and the top level; depends on nothing.

package prld_pkg;

   localparam int unsigned PosWidth = 17;
   localparam int unsigned CntWidth = 4;
   localparam logic [7:0] NibbleMask = 8'h0f;
   localparam logic [PosWidth-1:0] TargetReset = 17'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_RUN1,
      ST_RUN2
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;         // capture a request
      logic load_first;   // run count from the high nibble
      logic load_second;  // run count from the low nibble
      logic emit;         // put one byte into the output register
      logic sel_second;   // byte comes from the second value
      logic dec;          // count down the current run
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic finished;     // position at or past the target
      logic at_end;       // next byte lands on target minus one
      logic cnt_zero;     // current run has one byte left
      logic slot_free;    // output register can take a byte
   } dp_sts_type;

endpackage

// File: sv/paired_run_length_decoder.sv
// Paired run-length decoder. Each request is one code word; it expands into
// up to 32 bytes (high nibble plus one copies of the first value, then low
// nibble plus one copies of the second value), cut at target_size bytes since
// the last start. A request is accepted, its position is checked against the
// target, then it yields 0 to 32 bytes, one byte per cycle through the single
// output register while the output is not stalled. A request that yields
// nothing ends after the check.
// Write target_size only while no request is in flight.

module paired_run_length_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // command, first_value, second_value
   input  logic                              req_tuser,  // start_req
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,  // value
   output logic                              rsp_tlast,  // last
   output logic                              rsp_tuser,  // done_res
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [prld_pkg::PosWidth-1:0]     csr_data    // target_size
);

   prld_pkg::ctl_cmd_type cmd;
   prld_pkg::dp_sts_type  sts;

   assign csr_ready = 1'b1;

   prld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   prld_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .command      (req_tdata[7:0]),
      .first_value  (req_tdata[15:8]),
      .second_value (req_tdata[23:16]),
      .start_req    (req_tuser),
      .csr_wr       (csr_valid && csr_ready),
      .csr_value    (csr_data),
      .out_ready    (rsp_tready),
      .out_valid    (rsp_tvalid),
      .out_value    (rsp_tdata),
      .out_last     (rsp_tlast),
      .out_done     (rsp_tuser)
   );

   // a byte at the target is always the final byte of its request
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("done byte without last");

   // never overwrite a byte that has not been taken
   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.slot_free)
      else $error("emit into occupied output register");

   // one request at a time
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // a new run count only arrives in cycles without a byte count-down
   a_count_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.load_first || cmd.load_second |-> !cmd.dec)
      else $error("run counter loaded and decremented together");

endmodule

// File: sv/prld_dpath.sv
// Datapath of the paired run-length decoder: request registers, position,
// run counter, target register and the output register. Depends on prld_pkg.

module prld_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  prld_pkg::ctl_cmd_type              cmd,
   output prld_pkg::dp_sts_type               sts,
   input  logic [7:0]                         command,
   input  logic [7:0]                         first_value,
   input  logic [7:0]                         second_value,
   input  logic                               start_req,
   input  logic                               csr_wr,
   input  logic [prld_pkg::PosWidth-1:0]      csr_value,
   input  logic                               out_ready,
   output logic                               out_valid,
   output logic [7:0]                         out_value,
   output logic                               out_last,
   output logic                               out_done
);

   logic [7:0]                        command_ff, command_in;
   logic [7:0]                        first_ff, first_in;
   logic [7:0]                        second_ff, second_in;
   logic [prld_pkg::PosWidth-1:0]     pos_ff, pos_in;
   logic [prld_pkg::PosWidth-1:0]     target_ff, target_in;
   logic [prld_pkg::CntWidth-1:0]     cnt_ff, cnt_in;
   logic [7:0]                        value_ff, value_in;
   logic                              last_ff, last_in;
   logic                              done_ff, done_in;
   logic                              valid_ff, valid_in;
   logic [prld_pkg::PosWidth-1:0]     pos_next;

   // only used while pos < target, so it cannot wrap
   assign pos_next = pos_ff + prld_pkg::PosWidth'(1);

   assign sts.finished  = (pos_ff >= target_ff);
   assign sts.at_end    = (pos_next == target_ff);
   assign sts.cnt_zero  = (cnt_ff == '0);
   assign sts.slot_free = !valid_ff || out_ready;

   always_comb begin
      command_in = command_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      pos_in     = pos_ff;
      target_in  = target_ff;
      cnt_in     = cnt_ff;
      value_in   = value_ff;
      last_in    = last_ff;
      done_in    = done_ff;
      valid_in   = valid_ff;

      if (csr_wr) begin
         target_in = csr_value;
      end

      if (cmd.load) begin
         command_in = command;
         first_in   = first_value;
         second_in  = second_value;
         if (start_req) begin
            pos_in = '0;
         end
      end

      if (cmd.load_first) begin
         cnt_in = prld_pkg::CntWidth'((command_ff >> 4) & prld_pkg::NibbleMask);
      end else if (cmd.load_second) begin
         cnt_in = prld_pkg::CntWidth'(command_ff & prld_pkg::NibbleMask);
      end else if (cmd.dec) begin
         cnt_in = cnt_ff - prld_pkg::CntWidth'(1);
      end

      if (cmd.emit) begin
         value_in = cmd.sel_second ? second_ff : first_ff;
         last_in  = sts.at_end || (cmd.sel_second && sts.cnt_zero);
         done_in  = sts.at_end;
         pos_in   = pos_next;
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         target_ff <= prld_pkg::TargetReset;
         valid_ff  <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         target_ff <= target_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      command_ff <= command_in;
      first_ff   <= first_in;
      second_ff  <= second_in;
      cnt_ff     <= cnt_in;
      value_ff   <= value_in;
      last_ff    <= last_in;
      done_ff    <= done_in;
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;
   assign out_last  = last_ff;
   assign out_done  = done_ff;

endmodule

// File: sv/prld_ctrl.sv
// Controller of the paired run-length decoder: sequences evaluation, first run
// and second run of one code word. Depends on prld_pkg.

module prld_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  prld_pkg::dp_sts_type   sts,
   output prld_pkg::ctl_cmd_type  cmd
);

   prld_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prld_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = prld_pkg::ST_EVAL;
            end
         end
         prld_pkg::ST_EVAL: begin
            state_in = sts.finished ? prld_pkg::ST_IDLE : prld_pkg::ST_RUN1;
         end
         prld_pkg::ST_RUN1: begin
            if (sts.slot_free) begin
               if (sts.at_end) begin
                  state_in = prld_pkg::ST_IDLE;
               end else if (sts.cnt_zero) begin
                  state_in = prld_pkg::ST_RUN2;
               end
            end
         end
         prld_pkg::ST_RUN2: begin
            if (sts.slot_free && (sts.at_end || sts.cnt_zero)) begin
               state_in = prld_pkg::ST_IDLE;
            end
         end
         default: state_in = prld_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         prld_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         prld_pkg::ST_EVAL: begin
            cmd.load_first = !sts.finished;
         end
         prld_pkg::ST_RUN1: begin
            if (sts.slot_free) begin
               cmd.emit = 1'b1;
               // switch to the second run once the first is drained, unless the target is reached
               if (sts.cnt_zero) begin
                  cmd.load_second = !sts.at_end;
               end else begin
                  cmd.dec = 1'b1;
               end
            end
         end
         prld_pkg::ST_RUN2: begin
            if (sts.slot_free) begin
               cmd.emit       = 1'b1;
               cmd.sel_second = 1'b1;
               cmd.dec        = 1'b1;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prld_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: tb/sv/run_decode_checker.sv
// Checker for the paired run-length decoder: watches the request, response
// and csr channels, predicts every decoded byte and compares in order.
// Depends on prld_pkg for the position width and the target reset value.

module run_decode_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [23:0]                   req_tdata,   // command, first_value, second_value
   input  logic                          req_tuser,   // start_req
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [7:0]                    rsp_tdata,   // value
   input  logic                          rsp_tlast,   // last
   input  logic                          rsp_tuser,   // done_res
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [prld_pkg::PosWidth-1:0] csr_data,    // target_size
   output int                            mismatches,
   output int                            pending
);

   typedef struct packed {
      logic [7:0] value;
      logic       last;
      logic       done;
   } decoded_byte_type;

   decoded_byte_type decoded_q[$];
   logic [prld_pkg::PosWidth-1:0] target_size;
   logic [prld_pkg::PosWidth-1:0] out_pos;

   // Append up to len copies of fill, stopping at the target.
   task automatic emit_run(input logic [7:0] fill, input int unsigned len);
      decoded_byte_type entry;
      int unsigned      n;
      n = 0;
      while (n < len && out_pos < target_size) begin
         entry.value = fill;
         entry.last  = 1'b0;
         entry.done  = ({1'b0, out_pos} + 18'd1 == {1'b0, target_size});
         decoded_q   = {decoded_q, entry};
         out_pos = out_pos + 1'b1;
         n++;
      end
   endtask

   task automatic expand_code_word(input logic [23:0] word, input logic start);
      int base;
      base = decoded_q.size();
      if (start)
         out_pos = '0;
      if (out_pos < target_size) begin
         emit_run(word[15:8], int'(word[7:4]) + 1);
         // second run is skipped by emit_run when the first one hit the target
         emit_run(word[23:16], int'(word[3:0]) + 1);
         if (decoded_q.size() > base)
            decoded_q[decoded_q.size()-1].last = 1'b1;
      end
   endtask

   always @(posedge clock) begin : watch
      decoded_byte_type want;
      if (reset) begin
         target_size = prld_pkg::TargetReset;
         out_pos     = '0;
         decoded_q.delete();
         mismatches  = 0;
      end else begin
         if (csr_valid && csr_ready)
            target_size = csr_data;
         if (req_tvalid && req_tready)
            expand_code_word(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               $display("%0t: unexpected byte: expected none, actual value=%h last=%b done=%b",
                        $realtime, rsp_tdata, rsp_tlast, rsp_tuser);
               mismatches++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_tdata !== want.value || rsp_tlast !== want.last ||
                   rsp_tuser !== want.done) begin
                  $display({"%0t: byte mismatch: expected value=%h last=%b done=%b, ",
                            "actual value=%h last=%b done=%b"},
                           $realtime, want.value, want.last, want.done,
                           rsp_tdata, rsp_tlast, rsp_tuser);
                  mismatches++;
               end
            end
         end
      end
      pending = decoded_q.size();
   end

endmodule

// File: tb/sv/tb.sv
// Top of the paired run-length decoder testbench: clock, reset, request and
// csr stimulus, response back-pressure and the verdict.
// Depends on prld_pkg, paired_run_length_decoder and run_decode_checker.

module tb;

   localparam int CycleLimit    = 500000;
   localparam int HoldOffCycles = 300;
   localparam int SettleCycles  = 4;
   localparam int DrainCycles   = 40;
   localparam int PhaseCount    = 9;
   localparam int PhaseItems    = 40;
   localparam int PressurePhase = 3;
   localparam int SteadyPhase   = 5;
   localparam logic [prld_pkg::PosWidth-1:0] TargetMax = '1;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [23:0]                   req_tdata  = '0;
   logic                          req_tuser  = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [7:0]                    rsp_tdata;
   logic                          rsp_tlast;
   logic                          rsp_tuser;
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [prld_pkg::PosWidth-1:0] csr_data   = prld_pkg::TargetReset;

   int mismatches;
   int pending;
   int cycle_count  = 0;
   bit idle_en      = 1'b1;
   bit hold_off_req = 1'b0;

   paired_run_length_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   run_decode_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // Response side: random stalls, or one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_tready <= !idle_en || ($urandom_range(0, 99) >= 19);
         end
      end
   end

   task automatic offer_code_word(input logic [7:0] command, input logic [7:0] first_value,
                                  input logic [7:0] second_value, input logic start);
      if (idle_en && $urandom_range(0, 99) < 19) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {second_value, first_value, command};
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop the request, wait for every predicted byte, then let the block settle.
   task automatic drain_decoder();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_target(input logic [prld_pkg::PosWidth-1:0] target);
      drain_decoder();
      csr_valid <= 1'b1;
      csr_data  <= target;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [prld_pkg::PosWidth-1:0] phase_target;
      int                            start_pct;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // target still at its reset value of one
      offer_code_word(8'h00, 8'h5a, 8'ha5, 1'b0);
      offer_code_word(8'hff, 8'hff, 8'h00, 1'b0);  // stream finished
      offer_code_word(8'h37, 8'h12, 8'h34, 1'b1);

      write_target('0);                             // nothing ever comes out
      offer_code_word(8'hff, 8'h01, 8'h02, 1'b1);
      offer_code_word(8'h00, 8'h03, 8'h04, 1'b0);

      write_target(TargetMax);
      offer_code_word(8'hff, 8'hff, 8'h00, 1'b1);  // longest code word
      offer_code_word(8'h00, 8'h00, 8'hff, 1'b0);  // shortest code word
      offer_code_word(8'hf0, 8'haa, 8'h55, 1'b0);
      offer_code_word(8'h0f, 8'h55, 8'haa, 1'b0);

      write_target(17'd5);
      offer_code_word(8'h22, 8'h11, 8'h22, 1'b1);  // second run cut
      offer_code_word(8'h4f, 8'h33, 8'h44, 1'b1);  // first run ends on target
      offer_code_word(8'hf0, 8'h66, 8'h77, 1'b1);  // first run cut
      offer_code_word(8'h00, 8'h88, 8'h99, 1'b0);

      write_target(17'd100);
      offer_code_word(8'hff, 8'hc3, 8'h3c, 1'b1);
      offer_code_word(8'hff, 8'h81, 8'h7e, 1'b0);
      write_target(17'd40);                         // now below the position
      offer_code_word(8'h11, 8'he7, 8'h18, 1'b0);
      offer_code_word(8'h11, 8'he7, 8'h18, 1'b1);

      for (int p = 0; p < PhaseCount; p++) begin
         idle_en = (p != SteadyPhase);
         if (p == 0)
            phase_target = 17'd1;
         else if (p == PhaseCount - 1)
            phase_target = TargetMax;
         else if (p == PressurePhase)
            phase_target = 17'd3000;
         else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: phase_target = prld_pkg::PosWidth'($urandom_range(1, 64));
               5, 6, 7, 8:    phase_target = prld_pkg::PosWidth'($urandom_range(65, 1500));
               default:       phase_target = prld_pkg::PosWidth'($urandom_range(1501, 131071));
            endcase
         end
         write_target(phase_target);
         if (p == PressurePhase)
            hold_off_req = 1'b1;
         // restart more often when short targets finish the stream quickly
         start_pct = (phase_target <= 64) ? 50 : 20;
         for (int i = 0; i < PhaseItems; i++)
            offer_code_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)),
                            (i == 0) || ($urandom_range(0, 99) < start_pct));
      end

      drain_decoder();
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: files.f
sv/prld_pkg.sv
sv/prld_dpath.sv
sv/prld_ctrl.sv
sv/paired_run_length_decoder.sv
tb/sv/run_decode_checker.sv
tb/sv/tb.sv
